// ===== design/tpg_pkg.sv =====
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared types, sizes and helpers for the tile pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpg_pkg;

  // screen and store sizes
  localparam int TILE_COLUMNS    = 32;
  localparam int TILE_ROWS       = 32;
  localparam int PEN_COUNT       = 32;
  localparam int PEN_BITS        = $clog2(PEN_COUNT);
  localparam int CHAR_BANK_BYTES = 2048;
  localparam int CHAR_AW         = $clog2(CHAR_BANK_BYTES);

  localparam int CODE_DEPTH      = 1024;
  localparam int CODE_AW         = $clog2(CODE_DEPTH);
  localparam int PLANE_BYTES     = 2048;
  localparam int PLANE_AW        = $clog2(PLANE_BYTES);
  localparam int PLANE_COUNT     = 3;
  localparam int TILE_BANK_BYTES = PLANE_BYTES * PLANE_COUNT;

  // field widths
  localparam int ADDR_W  = 13;
  localparam int WDATA_W = 24;
  localparam int RGB_W   = 24;
  localparam int PIX_W   = 8;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    FUNC_CODE_WR = 3'd0,
    FUNC_ATTR_WR = 3'd1,
    FUNC_CHAR_WR = 3'd2,
    FUNC_TILE_WR = 3'd3,
    FUNC_PAL_WR  = 3'd4,
    FUNC_PIXEL   = 3'd5,
    FUNC_FRAME   = 3'd6,
    FUNC_ATTR_RD = 3'd7
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [ADDR_W-1:0]  addr;
    logic [WDATA_W-1:0] wdata;
    logic [PIX_W-1:0]   pix_x;
    logic [PIX_W-1:0]   pix_y;
  } item_t;

  typedef struct packed {
    logic             is_pixel;
    logic [4:0]       pen_index;
    logic [RGB_W-1:0] pixel_rgb;
    logic [7:0]       read_byte;
  } result_t;

  // palette contents after reset: odd pens 3..15 carry fixed colors
  function automatic logic [RGB_W-1:0] palette_preset(input logic [PEN_BITS-1:0] pen);
    logic [RGB_W-1:0] rgb;
    rgb = '0;
    case (pen)
      PEN_BITS'(3):  rgb = 24'hFFFF00;
      PEN_BITS'(5):  rgb = 24'h00FF00;
      PEN_BITS'(7):  rgb = 24'hFF0000;
      PEN_BITS'(9):  rgb = 24'h0000FF;
      PEN_BITS'(11): rgb = 24'hFF00FF;
      PEN_BITS'(13): rgb = 24'h00FFFF;
      PEN_BITS'(15): rgb = 24'hFFFFFF;
      default:       rgb = '0;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

// ===== design/tpg_tile_ram.sv =====
// ----------------------------------------------------------------------------
// tpg_tile_ram
// Tile code and attribute RAMs with the post-reset clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module tpg_tile_ram (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid,
  input  wire tpg_pkg::item_t item,
  output logic               clearing,
  output logic [7:0]         code,
  output logic [7:0]         attr
);
  import tpg_pkg::*;

  logic [7:0]         code_mem [CODE_DEPTH];
  logic [7:0]         attr_mem [CODE_DEPTH];
  logic [CODE_AW-1:0] clr_addr;
  logic [7:0]         attr0;       // live value of attribute byte 0; a frame op sets bit 7 if bit 2 is set
  logic [7:0]         attr0_snap;
  logic               sel0;
  logic [7:0]         attr_q;

  logic [4:0]         tx;
  logic [4:0]         ty;
  logic [10:0]        idx_full;
  logic [CODE_AW-1:0] rd_addr;
  logic [CODE_AW-1:0] wr_addr;
  logic [7:0]         wr_data;
  logic               in_range;
  logic               code_we;
  logic               attr_we;

  always_comb begin
    tx       = item.pix_x[7:3];
    ty       = item.pix_y[7:3];
    idx_full = 11'(ty) * 11'(TILE_COLUMNS) + 11'(tx);
    rd_addr  = (item.func == FUNC_PIXEL) ? idx_full[CODE_AW-1:0] : item.addr[CODE_AW-1:0];
    in_range = item.addr < ADDR_W'(CODE_DEPTH);
    wr_addr  = clearing ? clr_addr : item.addr[CODE_AW-1:0];
    wr_data  = clearing ? 8'd0 : item.wdata[7:0];
    code_we  = clearing || (valid && item.func == FUNC_CODE_WR && in_range);
    attr_we  = clearing || (valid && item.func == FUNC_ATTR_WR && in_range);
    attr     = sel0 ? attr0_snap : attr_q;
  end

  always_ff @(posedge clk) begin
    if (code_we) begin
      code_mem[wr_addr] <= wr_data;
    end
    code <= code_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (attr_we) begin
      attr_mem[wr_addr] <= wr_data;
    end
    attr_q <= attr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    sel0       <= (rd_addr == '0);
    attr0_snap <= attr0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      attr0    <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == CODE_AW'(CODE_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (valid && item.func == FUNC_ATTR_WR && item.addr == '0) begin
        attr0 <= item.wdata[7:0];
      end else if (valid && item.func == FUNC_FRAME) begin
        attr0[7] <= attr0[7] | attr0[2];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/tpg_pattern_mem.sv =====
// ----------------------------------------------------------------------------
// tpg_pattern_mem
// Character pattern bank and the three tile pattern planes.
// ----------------------------------------------------------------------------
`default_nettype none

module tpg_pattern_mem (
  input  wire logic                           clk,
  input  wire logic                           valid,
  input  wire tpg_pkg::item_t                 item,
  input  wire logic [7:0]                     code,
  output logic [7:0]                          char_byte,
  output logic [tpg_pkg::PLANE_COUNT-1:0][7:0] plane_bytes
);
  import tpg_pkg::*;

  logic [7:0]          char_mem [CHAR_BANK_BYTES];
  logic [10:0]         line;   // code*8 + row, wrapped to 11 bits
  logic                char_we;
  logic                tile_ok;

  always_comb begin
    line    = {code, item.pix_y[2:0]};
    char_we = valid && item.func == FUNC_CHAR_WR && item.addr < ADDR_W'(CHAR_BANK_BYTES);
    tile_ok = valid && item.func == FUNC_TILE_WR && item.addr < ADDR_W'(TILE_BANK_BYTES);
  end

  always_ff @(posedge clk) begin
    if (char_we) begin
      char_mem[item.addr[CHAR_AW-1:0]] <= item.wdata[7:0];
    end
    char_byte <= char_mem[line[CHAR_AW-1:0]];
  end

  // plane p sits at byte offset p*PLANE_BYTES
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    logic [7:0] plane_mem [PLANE_BYTES];
    logic       we;

    assign we = tile_ok && (item.addr[ADDR_W-1:PLANE_AW] == (ADDR_W - PLANE_AW)'(p));

    always_ff @(posedge clk) begin
      if (we) begin
        plane_mem[item.addr[PLANE_AW-1:0]] <= item.wdata[7:0];
      end
      plane_bytes[p] <= plane_mem[line[PLANE_AW-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== design/tpg_palette.sv =====
// ----------------------------------------------------------------------------
// tpg_palette
// Pen build from pattern bits, palette registers and result assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module tpg_palette (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            valid,
  input  wire tpg_pkg::item_t                  item,
  input  wire logic [7:0]                      attr,
  input  wire logic [7:0]                      char_byte,
  input  wire logic [tpg_pkg::PLANE_COUNT-1:0][7:0] plane_bytes,
  output logic                                 push,
  output tpg_pkg::result_t                     result
);
  import tpg_pkg::*;

  logic [RGB_W-1:0]    palette [PEN_COUNT];
  logic [2:0]          sh;
  logic [2:0]          planes;
  logic [7:0]          raw_pen;
  logic [7:0]          pen;
  logic                off_grid;
  logic                is_pixel;
  logic                rd_ok;
  logic [RGB_W-1:0]    rgb;

  always_comb begin
    sh       = ~item.pix_x[2:0];   // bit 7 is the leftmost pixel
    planes   = {plane_bytes[2][sh], plane_bytes[1][sh], plane_bytes[0][sh]};
    off_grid = ({1'b0, item.pix_x[7:3]} >= 6'(TILE_COLUMNS))
            || ({1'b0, item.pix_y[7:3]} >= 6'(TILE_ROWS));
    if (attr[4]) begin
      raw_pen = {4'd0, attr[2:0], char_byte[sh]};
    end else begin
      raw_pen = 8'd16 + {2'd0, attr[2:0], planes};
    end
    pen      = off_grid ? 8'd0 : (raw_pen & 8'(PEN_COUNT - 1));
    rgb      = palette[pen[PEN_BITS-1:0]];
    is_pixel = (item.func == FUNC_PIXEL);
    rd_ok    = item.addr < ADDR_W'(CODE_DEPTH);
    push     = valid && (is_pixel || item.func == FUNC_ATTR_RD);

    result.is_pixel  = is_pixel;
    result.pen_index = is_pixel ? pen[4:0] : 5'd0;
    result.pixel_rgb = is_pixel ? rgb : '0;
    result.read_byte = (!is_pixel && rd_ok) ? attr : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PEN_COUNT; i++) begin
        palette[i] <= palette_preset(PEN_BITS'(i));
      end
    end else if (valid && item.func == FUNC_PAL_WR && item.addr < ADDR_W'(PEN_COUNT)) begin
      palette[item.addr[PEN_BITS-1:0]] <= item.wdata;
    end
  end

endmodule

`default_nettype wire

// ===== design/tpg_out_fifo.sv =====
// ----------------------------------------------------------------------------
// tpg_out_fifo
// Small result queue between the pipeline and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tpg_out_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire tpg_pkg::result_t   wr,
  output logic                    valid,
  input  wire logic               ready,
  output tpg_pkg::result_t        rd,
  output logic [tpg_pkg::FIFO_AW:0] count
);
  import tpg_pkg::*;

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic               pop;

  always_comb begin
    valid = (count != '0);
    pop   = valid && ready;
    rd    = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/tilemap_pixel_generator.sv =====
// ----------------------------------------------------------------------------
// tilemap_pixel_generator
// Tile video generator: tile RAMs, pattern banks, palette, one op per beat.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata bits (low -> high)                 tuser
//  -------  ---  ----------------------------------------  --------------
//  s_*      in   addr 13, wdata 24, pix_x 8, pix_y 8, pad   func (3 bits)
//  m_*      out  pen_index 5, pixel_rgb 24, read_byte 8, pad is_pixel (1)
//
//  One transaction per clock sustained while m_tready stays high. A result
//  reaches m_tvalid through the input register, the code/attr RAM read, the
//  pattern RAM read, then the palette lookup into the result queue.
//  After rst the code and attribute RAMs are swept to zero with s_tready
//  low. s_tready also drops while eight transactions are in the pipeline
//  or queued, so a stalled m_tready never loses a result.
// ----------------------------------------------------------------------------
`default_nettype none

module tilemap_pixel_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // addr[12:0], wdata[36:13], pix_x[44:37], pix_y[52:45]
  input  wire logic [2:0]  s_tuser,   // func[2:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // pen_index[4:0], pixel_rgb[28:5], read_byte[36:29]
  output logic             m_tuser    // is_pixel
);
  import tpg_pkg::*;

  item_t                       in_item;

  // pipeline stages: s1 = input register, s2 = tile RAM data, s3 = pattern data
  logic                        s1_valid;
  item_t                       s1_item;
  logic                        s2_valid;
  item_t                       s2_item;
  logic                        s3_valid;
  item_t                       s3_item;
  logic [7:0]                  s3_attr;

  logic                        clearing;
  logic [7:0]                  code;
  logic [7:0]                  attr;
  logic [7:0]                  char_byte;
  logic [PLANE_COUNT-1:0][7:0] plane_bytes;
  logic                        push;
  result_t                     result;
  result_t                     out_res;
  logic [FIFO_AW:0]            fifo_count;
  logic [FIFO_AW+1:0]          occupancy;

  always_comb begin
    in_item.func  = func_t'(s_tuser);
    in_item.addr  = s_tdata[12:0];
    in_item.wdata = s_tdata[36:13];
    in_item.pix_x = s_tdata[44:37];
    in_item.pix_y = s_tdata[52:45];

    // credit: every item in flight keeps a queue slot in reserve
    occupancy = {1'b0, fifo_count} + (FIFO_AW + 2)'(s1_valid)
              + (FIFO_AW + 2)'(s2_valid) + (FIFO_AW + 2)'(s3_valid);
    s_tready  = !clearing && (occupancy < (FIFO_AW + 2)'(FIFO_DEPTH));

    m_tdata   = {3'd0, out_res.read_byte, out_res.pixel_rgb, out_res.pen_index};
    m_tuser   = out_res.is_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= s_tvalid && s_tready;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_item <= in_item;
    s2_item <= s1_item;
    s3_item <= s2_item;
    s3_attr <= attr;
  end

  tpg_tile_ram u_tile_ram (
    .clk      (clk),
    .rst      (rst),
    .valid    (s1_valid),
    .item     (s1_item),
    .clearing (clearing),
    .code     (code),
    .attr     (attr)
  );

  tpg_pattern_mem u_pattern_mem (
    .clk         (clk),
    .valid       (s2_valid),
    .item        (s2_item),
    .code        (code),
    .char_byte   (char_byte),
    .plane_bytes (plane_bytes)
  );

  tpg_palette u_palette (
    .clk         (clk),
    .rst         (rst),
    .valid       (s3_valid),
    .item        (s3_item),
    .attr        (s3_attr),
    .char_byte   (char_byte),
    .plane_bytes (plane_bytes),
    .push        (push),
    .result      (result)
  );

  tpg_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wr    (result),
    .valid (m_tvalid),
    .ready (m_tready),
    .rd    (out_res),
    .count (fifo_count)
  );

endmodule

`default_nettype wire
